// ===== hdl/text_console_put_char_macros.svh =====
// Assertion macros for the text console checker.
`ifndef TEXT_CONSOLE_PUT_CHAR_MACROS_SVH
`define TEXT_CONSOLE_PUT_CHAR_MACROS_SVH

// Check an implication on the clock, held off during reset.
`define TCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a condition that must hold whenever a result word is shown.
`define TCP_ASSERT_ON_DONE(label, cond, msg) \
  `TCP_ASSERT(label, done_o |-> (cond), msg)

`endif

// ===== hdl/tcp_pkg.sv =====
// Shared constants, types and state codes of the text console.
`default_nettype none

package tcp_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Internal widths follow the geometry
  localparam int AW  = $clog2(CELLS);
  localparam int CW  = $clog2(COLUMNS);
  localparam int RW  = $clog2(ROWS);
  localparam int TCW = $clog2(COLUMNS + 8);
  localparam int RW1 = $clog2(ROWS + 1);

  // Fixed widths of the result fields
  localparam int LOC_W  = 11;
  localparam int COL_OW = 7;
  localparam int ROW_OW = 5;

  // Cell store
  localparam int          CELL_W    = 16;
  localparam logic [15:0] BLANK     = 16'h0F20;
  localparam int          COPY_LAST = (ROWS - 1) * COLUMNS - 1;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Command modes
  localparam logic MODE_PUT   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic [3:0] bg_color;
    logic [3:0] fg_color;
  } in_word_t;

  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic [COL_OW-1:0] cursor_column;
    logic [ROW_OW-1:0] cursor_row;
    logic              scrolled;
  } out_word_t;

  // Status from the cursor unit to the sequencer
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          scroll;
  } cur_stat_t;

  // Current cursor position
  typedef struct packed {
    logic [AW-1:0] loc;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
  } cur_pos_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/tcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/tcp_cursor.sv =====
// Cursor registers and next-position logic of the text console.
`default_nettype none

module tcp_cursor
  import tcp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     upd_i,
  input  wire in_word_t cmd_i,
  output      cur_stat_t stat_o,
  output      cur_pos_t  pos_o
);

  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [TCW-1:0] col_t;
  logic [RW1-1:0] row_t;
  logic [RW1-1:0] row_w;
  logic           printable;
  logic           scroll;

  assign printable = (cmd_i.char_code >= CH_SPACE) && (cmd_i.char_code <= CH_DEL);

  // Apply the control code or the advance
  always_comb begin
    col_t = TCW'(col_q);
    row_t = RW1'(row_q);
    priority if (cmd_i.char_code == CH_BS) begin
      if (col_q != '0) begin
        col_t = TCW'(col_q) - TCW'(1);
      end
    end else if (cmd_i.char_code == CH_TAB) begin
      col_t = (TCW'(col_q) + TCW'(8)) & ~TCW'(7);
    end else if (cmd_i.char_code == CH_CR) begin
      col_t = '0;
    end else if (cmd_i.char_code == CH_LF) begin
      col_t = '0;
      row_t = RW1'(row_q) + RW1'(1);
    end else if (printable) begin
      col_t = TCW'(col_q) + TCW'(1);
    end else begin
      col_t = TCW'(col_q);
    end
  end

  // Wrap past the last column, scroll past the last row
  always_comb begin
    row_w  = row_t;
    col_d  = CW'(col_t);
    if (col_t >= TCW'(COLUMNS)) begin
      col_d = '0;
      row_w = row_t + RW1'(1);
    end
    scroll = (row_w >= RW1'(ROWS));
    row_d  = scroll ? RW'(ROWS - 1) : RW'(row_w);
    if (cmd_i.mode == MODE_CLEAR) begin
      col_d  = '0;
      row_d  = '0;
      scroll = 1'b0;
    end
  end

  // Hold the cursor, advance it on update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (upd_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign stat_o.wr_en   = printable && (cmd_i.mode == MODE_PUT);
  assign stat_o.wr_addr = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);
  assign stat_o.scroll  = scroll;

  assign pos_o.loc = AW'(AW'(row_q) * AW'(COLUMNS)) + AW'(col_q);
  assign pos_o.col = col_q;
  assign pos_o.row = row_q;

endmodule

`default_nettype wire

// ===== hdl/text_console_put_char.sv =====
// Text console top level: sequencer, shared sweep adder, cell store and cursor.
// A put that does not scroll passes through ST_EXEC and ST_DONE; done_o is registered.
// A scroll copies each cell one row up, with a read state and a write state per cell, then
// blanks the bottom row in ST_FILL; a clear blanks every cell in ST_FILL.
// Throughput: busy drops with the done_o strobe, so the next word can start in that cycle.
// Reset: async, active low; all cells are blanked first; the receiver cannot stall.
`default_nettype none

module text_console_put_char
  import tcp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output      logic      busy,
  input  wire in_word_t  word_i,
  output      logic      done_o,
  output      out_word_t result_o
);

  state_e          state_q, state_d;
  logic [AW-1:0]   k_q, k_d;
  logic [AW-1:0]   add_b;
  logic [AW-1:0]   sum;
  logic            pend_q, pend_d;
  logic            scr_q, scr_d;
  logic            done_q;
  in_word_t        cmd_q;
  out_word_t       res_q;
  logic            accept;
  logic            upd;
  cur_stat_t       stat;
  cur_pos_t        pos;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  assign accept = start && !busy;

  // Shared sweep adder: source offset on reads, step otherwise
  assign add_b = (state_q == ST_COPY_RD) ? AW'(COLUMNS) : AW'(1);
  assign sum   = k_q + add_b;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (k_q == AW'(CELLS - 1)) begin
          state_d = pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (cmd_q.mode == MODE_CLEAR) begin
          state_d = ST_FILL;
        end else if (stat.scroll) begin
          state_d = ST_COPY_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        state_d = (k_q == AW'(COPY_LAST)) ? ST_FILL : ST_COPY_RD;
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store port, cursor update, sweep counter
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = BLANK;
    upd       = 1'b0;
    k_d       = k_q;
    pend_d    = pend_q;
    scr_d     = scr_q;
    unique case (state_q)
      ST_FILL: begin
        ram_we = 1'b1;
        k_d    = sum;
      end
      ST_IDLE: begin
        if (start) begin
          pend_d = 1'b1;
        end
      end
      ST_EXEC: begin
        ram_we    = stat.wr_en;
        ram_waddr = stat.wr_addr;
        ram_wdata = {cmd_q.bg_color, cmd_q.fg_color, cmd_q.char_code};
        upd       = 1'b1;
        scr_d     = stat.scroll;
        k_d       = '0;
      end
      ST_COPY_RD: begin
        k_d = k_q;
      end
      ST_COPY_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        k_d       = sum;
      end
      ST_DONE: begin
        pend_d = 1'b0;
      end
      default: begin
        k_d = k_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      k_q     <= '0;
      pend_q  <= 1'b0;
      scr_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      scr_q   <= scr_d;
      done_q  <= (state_q == ST_DONE);
    end
  end

  // Capture the command word, build the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= word_i;
    end
    if (state_q == ST_DONE) begin
      res_q.cursor_location <= LOC_W'(pos.loc);
      res_q.cursor_column   <= COL_OW'(pos.col);
      res_q.cursor_row      <= ROW_OW'(pos.row);
      res_q.scrolled        <= scr_q;
    end
  end

  tcp_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .cmd_i  (cmd_q),
    .stat_o (stat),
    .pos_o  (pos)
  );

  tcp_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (sum),
    .rdata_o (ram_rdata)
  );

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/tcp_checker.sv =====
// Port-level checker of the text console, bound to the top level.
`default_nettype none

`include "text_console_put_char_macros.svh"

module tcp_checker
  import tcp_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      done_o,
  input wire out_word_t result_o
);

  logic col_ok;
  logic row_ok;
  logic on_bottom;

  // Decode the reported cursor
  assign col_ok    = result_o.cursor_column < COL_OW'(COLUMNS);
  assign row_ok    = result_o.cursor_row < ROW_OW'(ROWS);
  assign on_bottom = result_o.cursor_row == ROW_OW'(ROWS - 1);

  // A taken command word makes the block busy at once
  `TCP_ASSERT(a_busy_after_start, start && !busy |=> busy, "not busy after start")

  // Result words never come in consecutive cycles
  `TCP_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")

  // Reported cursor stays on the screen
  `TCP_ASSERT_ON_DONE(a_cursor_range, col_ok && row_ok, "cursor off screen")

  // A scroll leaves the cursor on the bottom row
  `TCP_ASSERT_ON_DONE(a_scroll_row, !result_o.scrolled || on_bottom, "scroll not on bottom row")

endmodule

bind text_console_put_char tcp_checker u_chk (.*);

`default_nettype wire

// ===== sim/text_console_put_char_test.sv =====
// Testbench for the text console: cursor prediction and result word checks.
`timescale 1ns / 1ps

module text_console_put_char_test;
  import tcp_pkg::*;

  localparam int DIRECTED_WORDS = 24;
  localparam int RANDOM_WORDS   = 1700;
  // Slowest correct word is a scroll plus the longest idle burst
  localparam int SLOW_WORD      = 2 * CELLS + 32;
  localparam int CYCLE_LIMIT    =
    3 * (2 * CELLS + 64 + (DIRECTED_WORDS + RANDOM_WORDS) * SLOW_WORD);
  localparam int SETTLE_CYCLES  = 2 * CELLS;
  localparam int REPORT_MAX     = 10;

  // Tracks the cursor and holds the result words still due from the block
  class cursor_checker;
    logic [COL_OW-1:0] col;
    logic [ROW_OW-1:0] row;
    out_word_t         due_q[$];
    int unsigned       fault_count;

    function new();
      col         = '0;
      row         = '0;
      fault_count = 0;
    endfunction

    function void report(string what, int unsigned exp_val, int unsigned act_val);
      fault_count++;
      if (fault_count <= REPORT_MAX)
        $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
    endfunction

    // Advance the cursor for an accepted word and queue the result it must give
    function void note_word(in_word_t w);
      out_word_t e;
      e = '0;
      if (w.mode == MODE_CLEAR) begin
        col = '0;
        row = '0;
      end else begin
        case (w.char_code)
          CH_BS: begin
            if (col != 0) col = col - 1'b1;
          end
          CH_TAB: col = (col + 7'd8) & ~7'd7;
          CH_CR: col = '0;
          CH_LF: begin
            col = '0;
            row = row + 1'b1;
          end
          default: begin
            if (w.char_code >= CH_SPACE && w.char_code <= CH_DEL) col = col + 1'b1;
          end
        endcase
        // Wrap past the last column, scroll past the last row
        if (col >= COLUMNS) begin
          col = '0;
          row = row + 1'b1;
        end
        if (row >= ROWS) begin
          row        = ROW_OW'(ROWS - 1);
          e.scrolled = 1'b1;
        end
      end
      e.cursor_location = LOC_W'(row * COLUMNS + col);
      e.cursor_column   = col;
      e.cursor_row      = row;
      due_q.push_back(e);
    endfunction

    // Compare a strobed result word with the oldest one due
    function void check_word(out_word_t r);
      out_word_t e;
      if (due_q.size() == 0) begin
        report("unexpected result word, location", 0, r.cursor_location);
        return;
      end
      e = due_q.pop_front();
      if (r.cursor_location !== e.cursor_location)
        report("cursor_location", e.cursor_location, r.cursor_location);
      if (r.cursor_column !== e.cursor_column)
        report("cursor_column", e.cursor_column, r.cursor_column);
      if (r.cursor_row !== e.cursor_row)
        report("cursor_row", e.cursor_row, r.cursor_row);
      if (r.scrolled !== e.scrolled)
        report("scrolled", e.scrolled, r.scrolled);
    endfunction
  endclass

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start   = 1'b0;
  in_word_t  word_i  = '0;
  logic      busy;
  logic      done_o;
  out_word_t result_o;

  cursor_checker sb;
  int unsigned   cycles = 0;

  text_console_put_char DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .word_i   (word_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Check every strobed result word
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_word(result_o);
  end

  function automatic in_word_t put_word(logic [7:0] ch, logic [3:0] bg, logic [3:0] fg);
    in_word_t w;
    w.mode      = MODE_PUT;
    w.char_code = ch;
    w.bg_color  = bg;
    w.fg_color  = fg;
    return w;
  endfunction

  // Pick a random word; clear_pct sets how often the screen is cleared
  function automatic in_word_t random_word(int unsigned clear_pct);
    in_word_t    w;
    int unsigned pick;
    logic [7:0]  ch;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom);
    if (pick < clear_pct) begin
      w      = put_word(ch, 4'($urandom), 4'($urandom));
      w.mode = MODE_CLEAR;
      return w;
    end
    if (pick < 60) ch = 8'($urandom_range(CH_SPACE, CH_DEL));
    else if (pick < 70) ch = CH_BS;
    else if (pick < 75) ch = CH_TAB;
    else if (pick < 78) ch = CH_CR;
    else if (pick < 88) ch = CH_LF;
    else if ($urandom_range(0, 1) == 0) ch = 8'($urandom_range(8'h80, 8'hFF));
    else begin
      // Low byte that is not a control code: move a control code up by 0x10
      ch = 8'($urandom_range(8'h00, 8'h1F));
      if (ch == CH_BS || ch == CH_TAB || ch == CH_LF || ch == CH_CR) ch[4] = 1'b1;
    end
    return put_word(ch, 4'($urandom), 4'($urandom));
  endfunction

  // Hold start until the block takes the word, then maybe idle for a burst
  task automatic send_word(input in_word_t w, input bit may_idle);
    start  <= 1'b1;
    word_i <= w;
    do @(posedge clk_i); while (!(start && !busy));
    sb.note_word(w);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start  <= 1'b0;
      word_i <= in_word_t'($urandom);
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int count, input int unsigned clear_pct,
                             input bit may_idle);
    repeat (count) send_word(random_word(clear_pct), may_idle);
  endtask

  // Stop a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    in_word_t clr;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clear, field extremes, backspace down to column 0, ignored bytes
    clr      = put_word(8'hA5, 4'h3, 4'hC);
    clr.mode = MODE_CLEAR;
    send_word(clr, 1'b1);
    send_word(put_word(CH_SPACE, 4'h0, 4'h0), 1'b1);
    send_word(put_word(CH_DEL, 4'hF, 4'hF), 1'b1);
    send_word(put_word(CH_BS, 4'h0, 4'hF), 1'b1);
    send_word(put_word(CH_BS, 4'hF, 4'h0), 1'b1);
    send_word(put_word(CH_BS, 4'h5, 4'hA), 1'b1);
    send_word(put_word(8'h00, 4'h0, 4'h0), 1'b1);
    send_word(put_word(8'h1F, 4'hF, 4'hF), 1'b1);
    send_word(put_word(8'h80, 4'hA, 4'h5), 1'b1);
    send_word(put_word(8'hFF, 4'hF, 4'hF), 1'b1);
    send_word(put_word(8'h41, 4'h1, 4'h2), 1'b1);
    send_word(put_word(CH_CR, 4'h0, 4'h0), 1'b1);
    // Tab across the whole line, the last one wraps to the next row
    repeat (10) send_word(put_word(CH_TAB, 4'h0, 4'h7), 1'b1);
    send_word(put_word(CH_LF, 4'h0, 4'h0), 1'b1);
    send_word(put_word(8'h7E, 4'h9, 4'h6), 1'b1);

    // Random: with clears, then without so the screen scrolls, then without idling
    send_random(700, 3, 1'b1);
    send_random(500, 0, 1'b1);
    send_random(500, 2, 1'b0);

    start <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.fault_count == 0 && sb.due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tcp_pkg.sv
hdl/tcp_ram.sv
hdl/tcp_cursor.sv
hdl/text_console_put_char.sv
hdl/tcp_checker.sv
sim/text_console_put_char_test.sv
